@@ rtl/air_quality_sensor_plausibility_defines.svh @@
`ifndef AIR_QUALITY_SENSOR_PLAUSIBILITY_DEFINES_SVH
`define AIR_QUALITY_SENSOR_PLAUSIBILITY_DEFINES_SVH

// Concurrent checks on the block clock, off while reset is high.
`define AQSP_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`define AQSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/aqsp_pkg.sv @@
`timescale 1ns / 1ps

package aqsp_pkg;

   localparam int CO2_BITS = 14;
   localparam int AIR_BITS = 12;
   localparam int PIR_BITS = 8;
   localparam int INTERVAL_BITS = 11;
   localparam int ROWS_BITS = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS_CA = (CO2_BITS > AIR_BITS) ? CO2_BITS : AIR_BITS;
   localparam int CSR_DATA_BITS =
      (CSR_DATA_BITS_CA > INTERVAL_BITS) ? CSR_DATA_BITS_CA : INTERVAL_BITS;

   localparam logic [CO2_BITS-1:0] CO2_LOW_RESET = CO2_BITS'(418);
   localparam logic [CO2_BITS-1:0] CO2_HIGH_RESET = CO2_BITS'(630);
   localparam logic [AIR_BITS-1:0] AIR_LOW_RESET = AIR_BITS'(7);
   localparam logic [AIR_BITS-1:0] AIR_HIGH_RESET = AIR_BITS'(70);
   localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = INTERVAL_BITS'(60);
   localparam logic [INTERVAL_BITS-1:0] INTERVAL_FAST = INTERVAL_BITS'(30);

   localparam logic [ROWS_BITS-1:0] ROWS_FULL = ROWS_BITS'(4);

   // round(prev/10) = (prev + 5) / 10, done as multiply by reciprocal; exact below 2^32
   localparam logic [CO2_BITS-1:0] BAND_ROUND = CO2_BITS'(5);
   localparam int RECIP_BITS = 33;
   localparam logic [RECIP_BITS-1:0] BAND_RECIP = 33'h0_CCCC_CCCD;
   localparam int RECIP_SHIFT = 35;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CO2_LOW  = 3'd0,
      CSR_CO2_HIGH = 3'd1,
      CSR_AIR_LOW  = 3'd2,
      CSR_AIR_HIGH = 3'd3,
      CSR_INTERVAL = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                      series_start;
      logic [CO2_BITS-1:0]       co2_ppm;
      logic                      co2_present;
      logic [AIR_BITS-1:0]       airflow_value;
      logic                      airflow_present;
      logic [PIR_BITS-1:0]       pir_value;
      logic                      pir_present;
   } req_type;

   typedef struct packed {
      logic air_not_high;
      logic air_not_low;
      logic air_not_frozen;
      logic pir_matches_flow;
      logic co2_not_high;
      logic co2_not_low;
      logic co2_not_frozen;
      logic co2_step_small;
      logic pir_is_binary;
   } rsp_type;

   typedef struct packed {
      logic [CO2_BITS-1:0]      co2_low_limit;
      logic [CO2_BITS-1:0]      co2_high_limit;
      logic [AIR_BITS-1:0]      air_low_limit;
      logic [AIR_BITS-1:0]      air_high_limit;
      logic [INTERVAL_BITS-1:0] sample_interval_minutes;
   } cfg_type;

   // History as the current row sees it (already cleared on series start).
   typedef struct packed {
      logic [ROWS_BITS-1:0]     rows;
      logic [3:0][CO2_BITS-1:0] co2;
      logic [3:0]               co2_vld;
      logic [AIR_BITS-1:0]      air;
      logic                     air_vld;
      logic [CO2_BITS-1:0]      band;
   } hist_type;

endpackage

@@ rtl/aqsp_csr.sv @@
`timescale 1ns / 1ps

module aqsp_csr
   import aqsp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_CO2_LOW:  cfg_in.co2_low_limit = csr_wdata[CO2_BITS-1:0];
            CSR_CO2_HIGH: cfg_in.co2_high_limit = csr_wdata[CO2_BITS-1:0];
            CSR_AIR_LOW:  cfg_in.air_low_limit = csr_wdata[AIR_BITS-1:0];
            CSR_AIR_HIGH: cfg_in.air_high_limit = csr_wdata[AIR_BITS-1:0];
            CSR_INTERVAL: cfg_in.sample_interval_minutes = csr_wdata[INTERVAL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.co2_low_limit <= CO2_LOW_RESET;
         cfg_ff.co2_high_limit <= CO2_HIGH_RESET;
         cfg_ff.air_low_limit <= AIR_LOW_RESET;
         cfg_ff.air_high_limit <= AIR_HIGH_RESET;
         cfg_ff.sample_interval_minutes <= INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/aqsp_history.sv @@
`timescale 1ns / 1ps
`include "air_quality_sensor_plausibility_defines.svh"

module aqsp_history
   import aqsp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     update,
   input  req_type  item,
   output hist_type hist
);

   localparam int PROD_BITS = CO2_BITS + 1 + RECIP_BITS;

   logic [ROWS_BITS-1:0]     rows_ff, rows_in;
   logic [3:0][CO2_BITS-1:0] co2_ff, co2_in;
   logic [3:0]               co2_vld_ff, co2_vld_in;
   logic [AIR_BITS-1:0]      air_ff, air_in;
   logic                     air_vld_ff, air_vld_in;
   logic [CO2_BITS-1:0]      band_ff, band_in;

   logic [CO2_BITS:0]        band_num;
   logic [PROD_BITS-1:0]     band_prod;

   // Row view: a series start wipes the history before it is used.
   always_comb begin
      if (item.series_start) begin
         hist = '0;
      end else begin
         hist.rows = rows_ff;
         hist.co2 = co2_ff;
         hist.co2_vld = co2_vld_ff;
         hist.air = air_ff;
         hist.air_vld = air_vld_ff;
         hist.band = band_ff;
      end
   end

   // Band half-width of the sample that becomes the newest entry.
   assign band_num = {1'b0, item.co2_ppm} + {1'b0, BAND_ROUND};
   assign band_prod = PROD_BITS'(band_num) * PROD_BITS'(BAND_RECIP);

   always_comb begin
      rows_in = (hist.rows < ROWS_FULL) ? hist.rows + ROWS_BITS'(1) : hist.rows;
      co2_in = {hist.co2[2:0], (item.co2_present ? item.co2_ppm : CO2_BITS'(0))};
      co2_vld_in = {hist.co2_vld[2:0], item.co2_present};
      air_in = item.airflow_present ? item.airflow_value : AIR_BITS'(0);
      air_vld_in = item.airflow_present;
      band_in = CO2_BITS'(band_prod >> RECIP_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '0;
         co2_ff <= '0;
         co2_vld_ff <= '0;
         air_ff <= '0;
         air_vld_ff <= 1'b0;
         band_ff <= '0;
      end else if (update) begin
         rows_ff <= rows_in;
         co2_ff <= co2_in;
         co2_vld_ff <= co2_vld_in;
         air_ff <= air_in;
         air_vld_ff <= air_vld_in;
         band_ff <= band_in;
      end
   end

   `AQSP_ASSERT_ALWAYS(a_rows_saturate, rows_ff <= ROWS_FULL, "row count past saturation")
   `AQSP_ASSERT_NEXT(a_newest_valid, update, co2_vld_ff[0] == $past(item.co2_present), "newest CO2 valid bit wrong")
   `AQSP_ASSERT_NEXT(a_start_restarts, update && item.series_start, rows_ff == ROWS_BITS'(1), "series start did not restart count")
   `AQSP_ASSERT_NEXT(a_hold_idle, !update, $stable(rows_ff) && $stable(co2_vld_ff), "history moved without a row")

endmodule

@@ rtl/aqsp_check.sv @@
`timescale 1ns / 1ps

module aqsp_check
   import aqsp_pkg::*;
(
   input  req_type  item,
   input  hist_type hist,
   input  cfg_type  cfg,
   output rsp_type  flags
);

   logic [CO2_BITS:0] co2_wide;
   logic [CO2_BITS:0] prev_wide;
   logic [CO2_BITS:0] band_wide;
   logic              in_band;
   logic              all_vld;
   logic              all_same;
   logic              first_row;

   assign co2_wide = {1'b0, item.co2_ppm};
   assign prev_wide = {1'b0, hist.co2[0]};
   assign band_wide = {1'b0, hist.band};
   assign in_band = (co2_wide + band_wide >= prev_wide) && (co2_wide <= prev_wide + band_wide);
   assign all_vld = &hist.co2_vld;
   assign all_same = (item.co2_ppm == hist.co2[0]) && (item.co2_ppm == hist.co2[1]) &&
                     (item.co2_ppm == hist.co2[2]) && (item.co2_ppm == hist.co2[3]);
   assign first_row = (hist.rows == '0);

   always_comb begin
      flags = '0;

      if (item.co2_present) begin
         if (item.co2_ppm <= cfg.co2_low_limit) begin
            flags.co2_not_high = 1'b1;
         end else if (item.co2_ppm >= cfg.co2_high_limit) begin
            flags.co2_not_low = 1'b1;
         end else begin
            flags.co2_not_high = 1'b1;
            flags.co2_not_low = 1'b1;
         end

         if (hist.rows >= ROWS_FULL) begin
            if ((cfg.sample_interval_minutes < INTERVAL_FAST) && all_vld) begin
               flags.co2_not_frozen = !all_same;
            end else if (hist.co2_vld[0]) begin
               flags.co2_not_frozen = (item.co2_ppm != hist.co2[0]);
            end else begin
               flags.co2_not_frozen = 1'b0;
            end
         end else begin
            flags.co2_not_frozen = 1'b1;
         end

         flags.co2_step_small = first_row || (hist.co2_vld[0] && in_band);
      end

      if (item.airflow_present) begin
         if (item.airflow_value >= cfg.air_high_limit) begin
            flags.air_not_low = 1'b1;
         end else if (item.airflow_value <= cfg.air_low_limit) begin
            flags.air_not_high = 1'b1;
         end else begin
            flags.air_not_high = 1'b1;
            flags.air_not_low = 1'b1;
         end

         if (first_row) begin
            flags.air_not_frozen = 1'b1;
         end else if (hist.air_vld && item.co2_present && hist.co2_vld[0]) begin
            flags.air_not_frozen = !(in_band && (item.airflow_value == hist.air));
         end else begin
            flags.air_not_frozen = 1'b0;
         end
      end

      if (item.pir_present) begin
         flags.pir_matches_flow = item.airflow_present &&
            ((item.pir_value != '0) == (item.airflow_value != '0));
         flags.pir_is_binary = (item.pir_value <= PIR_BITS'(1));
      end
   end

endmodule

@@ rtl/air_quality_sensor_plausibility.sv @@
`timescale 1ns / 1ps

// Plausibility checks for a stream of sensor rows (CO2, airflow, PIR). One row
// is taken per clock and its nine pass/fail flags are presented after the row
// passes the input register, then the result register; the history update
// and all checks fit in the single stage between them, so one row per cycle is
// sustained while rsp_ready stays high. A stalled result holds the pipe, and
// req_ready falls only when both registers are full. Register writes on the csr
// port are registered and must be made while no row is in flight.

module air_quality_sensor_plausibility
   import aqsp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic     in_valid_ff, in_valid_in;
   req_type  in_data_ff;
   logic     out_valid_ff, out_valid_in;
   rsp_type  out_data_ff;
   logic     move;
   cfg_type  cfg;
   hist_type hist;
   rsp_type  flags;

   assign move = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || move;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !move);
   assign out_valid_in = move || (out_valid_ff && !rsp_ready);

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

   aqsp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   aqsp_history u_history (
      .clock  (clock),
      .reset  (reset),
      .update (move),
      .item   (in_data_ff),
      .hist   (hist)
   );

   aqsp_check u_check (
      .item  (in_data_ff),
      .hist  (hist),
      .cfg   (cfg),
      .flags (flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (move) begin
         out_data_ff <= flags;
      end
   end

endmodule

@@ bench/air_quality_sensor_plausibility_test.sv @@
`timescale 1ns / 1ps

module air_quality_sensor_plausibility_test;
   import aqsp_pkg::*;

   localparam int CO2_MAX = (1 << CO2_BITS) - 1;
   localparam int AIR_MAX = (1 << AIR_BITS) - 1;
   localparam int PIR_MAX = (1 << PIR_BITS) - 1;
   localparam int INTERVAL_MAX = 1440;
   localparam int STUCK_LIMIT = 5000;
   localparam int ROWS_PER_PHASE = 240;

   typedef struct {
      logic          is_reg;
      csr_index_type index;
      int            value;
      req_type       row;
      logic          pinned;
      rsp_type       flags;
   } plan_step_type;

   typedef struct packed {
      logic    pinned;
      rsp_type flags;
   } pinned_flags_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   air_quality_sensor_plausibility i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block's registers and history
   cfg_type limits = '{CO2_LOW_RESET, CO2_HIGH_RESET, AIR_LOW_RESET, AIR_HIGH_RESET,
                       INTERVAL_RESET};
   int unsigned seen_rows = 0;
   logic [3:0][CO2_BITS-1:0] co2_hist = '0;
   logic [3:0] co2_hist_ok = '0;
   logic [AIR_BITS-1:0] last_air = '0;
   logic last_air_ok = 1'b0;

   rsp_type flags_due[$];
   pinned_flags_type flags_pinned_q[$];
   plan_step_type plan[$];
   string flag_names [0:8] = '{"pir_is_binary", "co2_step_small", "co2_not_frozen",
                               "co2_not_low", "co2_not_high", "pir_matches_flow",
                               "air_not_frozen", "air_not_low", "air_not_high"};

   int mismatches = 0;
   int rows_sent = 0;
   int results_seen = 0;
   int stuck_cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   // random series generator state
   int series_left = 0;
   int co2_walk = 0;
   int air_walk = 0;

   function automatic bit in_band(logic [CO2_BITS-1:0] value, logic [CO2_BITS-1:0] prev);
      int v;
      int p;
      int d;
      v = value;
      p = prev;
      d = (p + 5) / 10;
      return v >= p - d && v <= p + d;
   endfunction

   function automatic rsp_type judge_row(req_type r);
      rsp_type f;
      int unsigned row;
      logic same;
      if (r.series_start) begin
         seen_rows = 0;
         co2_hist = '0;
         co2_hist_ok = '0;
         last_air = '0;
         last_air_ok = 1'b0;
      end
      f = '0;
      row = seen_rows;
      if (r.co2_present) begin
         if (r.co2_ppm <= limits.co2_low_limit) begin
            f.co2_not_high = 1'b1;
         end else if (r.co2_ppm >= limits.co2_high_limit) begin
            f.co2_not_low = 1'b1;
         end else begin
            f.co2_not_high = 1'b1;
            f.co2_not_low = 1'b1;
         end
         if (row >= 4) begin
            same = r.co2_ppm == co2_hist[0] && r.co2_ppm == co2_hist[1] &&
                   r.co2_ppm == co2_hist[2] && r.co2_ppm == co2_hist[3];
            if (limits.sample_interval_minutes < INTERVAL_FAST && &co2_hist_ok) begin
               f.co2_not_frozen = !same;
            end else if (co2_hist_ok[0]) begin
               f.co2_not_frozen = r.co2_ppm != co2_hist[0];
            end else begin
               f.co2_not_frozen = 1'b0;
            end
         end else begin
            f.co2_not_frozen = 1'b1;
         end
         if (row > 0) begin
            f.co2_step_small = co2_hist_ok[0] && in_band(r.co2_ppm, co2_hist[0]);
         end else begin
            f.co2_step_small = 1'b1;
         end
      end
      if (r.airflow_present) begin
         if (r.airflow_value >= limits.air_high_limit) begin
            f.air_not_low = 1'b1;
         end else if (r.airflow_value <= limits.air_low_limit) begin
            f.air_not_high = 1'b1;
         end else begin
            f.air_not_high = 1'b1;
            f.air_not_low = 1'b1;
         end
         if (row > 0) begin
            if (last_air_ok && r.co2_present && co2_hist_ok[0]) begin
               f.air_not_frozen = !(in_band(r.co2_ppm, co2_hist[0]) &&
                                    r.airflow_value == last_air);
            end else begin
               f.air_not_frozen = 1'b0;
            end
         end else begin
            f.air_not_frozen = 1'b1;
         end
      end
      if (r.pir_present) begin
         f.pir_matches_flow = r.airflow_present &&
                              ((r.pir_value != 0) == (r.airflow_value != 0));
         f.pir_is_binary = r.pir_value <= 1;
      end
      co2_hist = {co2_hist[2:0], r.co2_present ? r.co2_ppm : CO2_BITS'(0)};
      co2_hist_ok = {co2_hist_ok[2:0], r.co2_present};
      last_air = r.airflow_present ? r.airflow_value : AIR_BITS'(0);
      last_air_ok = r.airflow_present;
      if (seen_rows < 4) seen_rows++;
      return f;
   endfunction

   function automatic int clamp_to(int v, int maxv);
      if (v < 0) return 0;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic int near(int lim, int maxv);
      return clamp_to(lim + int'($urandom_range(0, 2)) - 1, maxv);
   endfunction

   function automatic req_type make_row(bit start, int co2, bit co2_ok, int air, bit air_ok,
                                        int pir, bit pir_ok);
      req_type r;
      r.series_start = start;
      r.co2_ppm = CO2_BITS'(co2);
      r.co2_present = co2_ok;
      r.airflow_value = AIR_BITS'(air);
      r.airflow_present = air_ok;
      r.pir_value = PIR_BITS'(pir);
      r.pir_present = pir_ok;
      return r;
   endfunction

   function automatic plan_step_type row_step(bit start, int co2, bit co2_ok, int air,
                                              bit air_ok, int pir, bit pir_ok);
      plan_step_type s;
      s.is_reg = 1'b0;
      s.index = CSR_CO2_LOW;
      s.value = 0;
      s.row = make_row(start, co2, co2_ok, air, air_ok, pir, pir_ok);
      s.pinned = 1'b0;
      s.flags = '0;
      return s;
   endfunction

   function automatic plan_step_type pin(plan_step_type s, rsp_type flags);
      s.pinned = 1'b1;
      s.flags = flags;
      return s;
   endfunction

   function automatic plan_step_type reg_step(csr_index_type index, int value);
      plan_step_type s;
      s = row_step(0, 0, 0, 0, 0, 0, 0);
      s.is_reg = 1'b1;
      s.index = index;
      s.value = value;
      return s;
   endfunction

   // mostly well-formed series with drifting CO2, some pure noise rows
   function automatic req_type next_random_row();
      int roll;
      int d;
      int step;
      int pir;
      bit start;
      if ($urandom_range(0, 99) < 12) begin
         return make_row($urandom_range(0, 1), $urandom_range(0, CO2_MAX),
                         $urandom_range(0, 1), $urandom_range(0, AIR_MAX),
                         $urandom_range(0, 1), $urandom_range(0, PIR_MAX),
                         $urandom_range(0, 1));
      end
      start = series_left == 0;
      if (start) begin
         series_left = $urandom_range(1, 12);
         roll = $urandom_range(0, 3);
         case (roll)
            0: co2_walk = $urandom_range(0, CO2_MAX);
            1: co2_walk = near(limits.co2_low_limit, CO2_MAX);
            2: co2_walk = near(limits.co2_high_limit, CO2_MAX);
            default: co2_walk = $urandom_range(300, 900);
         endcase
         air_walk = $urandom_range(0, 150);
      end else begin
         roll = $urandom_range(0, 99);
         d = (co2_walk + 5) / 10;
         if (roll < 30) begin
         end else if (roll < 65) begin
            step = $urandom_range(0, d);
            co2_walk = clamp_to($urandom_range(0, 1) ? co2_walk + step : co2_walk - step,
                                CO2_MAX);
         end else if (roll < 80) begin
            step = d + 1 + int'($urandom_range(0, 3));
            co2_walk = clamp_to($urandom_range(0, 1) ? co2_walk + step : co2_walk - step,
                                CO2_MAX);
         end else if (roll < 90) begin
            co2_walk = near($urandom_range(0, 1) ? limits.co2_low_limit :
                            limits.co2_high_limit, CO2_MAX);
         end else begin
            co2_walk = $urandom_range(0, CO2_MAX);
         end
         roll = $urandom_range(0, 99);
         if (roll < 45) begin
         end else if (roll < 60) begin
            air_walk = near($urandom_range(0, 1) ? limits.air_low_limit :
                            limits.air_high_limit, AIR_MAX);
         end else if (roll < 90) begin
            air_walk = $urandom_range(0, 150);
         end else begin
            air_walk = $urandom_range(0, AIR_MAX);
         end
      end
      series_left--;
      roll = $urandom_range(0, 99);
      pir = air_walk != 0;
      if (roll < 8) pir = $urandom_range(0, PIR_MAX);
      else if (roll < 23) pir = !pir;
      return make_row(start, co2_walk, $urandom_range(0, 99) < 92, air_walk,
                      $urandom_range(0, 99) < 92, pir, $urandom_range(0, 99) < 92);
   endfunction

   task automatic send_row(input req_type row, input logic pinned, input rsp_type flags);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      flags_pinned_q.push_back('{pinned, flags});
      req_valid <= 1'b1;
      req_data <= row;
      do @(posedge clock); while (!req_ready);
      rows_sent++;
   endtask

   task automatic write_reg(input csr_index_type index, input int value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= CSR_DATA_BITS'(value);
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic wait_drained();
      while (results_seen < rows_sent) @(posedge clock);
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= $urandom_range(0, 99) >= stall_pct;
   end

   always @(posedge clock) begin
      rsp_type want;
      rsp_type predicted;
      pinned_flags_type pinned;
      logic [$bits(rsp_type)-1:0] w;
      logic [$bits(rsp_type)-1:0] a;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (flags_due.size() == 0) begin
               mismatches++;
               $display("%0t: result beat with none expected, got %b", $time, rsp_data);
            end else begin
               want = flags_due.pop_front();
               w = want;
               a = rsp_data;
               for (int b = $bits(rsp_type) - 1; b >= 0; b--) begin
                  if (w[b] !== a[b]) begin
                     mismatches++;
                     $display("%0t: %s expected %b got %b", $time, flag_names[b], w[b], a[b]);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            pinned = flags_pinned_q.pop_front();
            predicted = judge_row(req_data);
            flags_due.push_back(pinned.pinned ? pinned.flags : predicted);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CO2_LOW: limits.co2_low_limit = csr_wdata[CO2_BITS-1:0];
               CSR_CO2_HIGH: limits.co2_high_limit = csr_wdata[CO2_BITS-1:0];
               CSR_AIR_LOW: limits.air_low_limit = csr_wdata[AIR_BITS-1:0];
               CSR_AIR_HIGH: limits.air_high_limit = csr_wdata[AIR_BITS-1:0];
               CSR_INTERVAL: limits.sample_interval_minutes = csr_wdata[INTERVAL_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("air_quality_sensor_plausibility verification failed");
         $finish;
      end
   end

   initial begin
      int lo_co2;
      int hi_co2;
      int lo_air;
      int hi_air;
      int interval;

      plan.push_back(pin(row_step(0, 0, 0, 0, 0, 0, 0), rsp_type'(9'b000_000_000)));
      plan.push_back(pin(row_step(1, 500, 1, 30, 1, 1, 1), rsp_type'(9'b111_111_111)));
      plan.push_back(row_step(0, 500, 1, 30, 1, 1, 1));
      plan.push_back(row_step(0, 550, 1, 30, 1, 0, 1));
      plan.push_back(row_step(0, 495, 1, 31, 1, 1, 1));
      plan.push_back(row_step(0, 546, 1, 31, 1, 1, 1));
      plan.push_back(row_step(0, 546, 1, 31, 1, 2, 1));
      plan.push_back(row_step(0, 0, 0, 100, 1, 0, 1));
      plan.push_back(row_step(0, 300, 1, 0, 0, 1, 1));
      plan.push_back(row_step(0, 300, 1, 5, 1, 0, 0));
      plan.push_back(pin(row_step(1, CO2_MAX, 1, AIR_MAX, 1, PIR_MAX, 1),
                         rsp_type'(9'b011_101_110)));
      plan.push_back(pin(row_step(1, 0, 1, 0, 1, 0, 1), rsp_type'(9'b101_110_111)));
      plan.push_back(pin(row_step(1, CO2_MAX, 0, AIR_MAX, 0, PIR_MAX, 0),
                         rsp_type'(9'b000_000_000)));
      // crossed limits and the five-sample frozen rule
      plan.push_back(reg_step(CSR_INTERVAL, 10));
      plan.push_back(reg_step(CSR_CO2_LOW, 700));
      plan.push_back(reg_step(CSR_CO2_HIGH, 600));
      plan.push_back(reg_step(CSR_AIR_LOW, 50));
      plan.push_back(reg_step(CSR_AIR_HIGH, 40));
      plan.push_back(pin(row_step(1, 650, 1, 45, 1, 1, 1), rsp_type'(9'b011_110_111)));
      repeat (4) plan.push_back(row_step(0, 650, 1, 45, 1, 1, 1));
      plan.push_back(row_step(0, 651, 1, 46, 1, 1, 1));

      do @(posedge clock); while (reset);

      foreach (plan[i]) begin
         if (plan[i].is_reg) begin
            req_valid <= 1'b0;
            wait_drained();
            write_reg(plan[i].index, plan[i].value);
         end else begin
            csr_valid <= 1'b0;
            send_row(plan[i].row, plan[i].pinned, plan[i].flags);
         end
      end

      for (int phase = 0; phase < 8; phase++) begin
         req_valid <= 1'b0;
         wait_drained();
         lo_co2 = $urandom_range(200, 600);
         hi_co2 = lo_co2 + int'($urandom_range(100, 600));
         lo_air = $urandom_range(0, 20);
         hi_air = $urandom_range(30, 120);
         case (phase)
            0: begin
               lo_co2 = CO2_LOW_RESET;
               hi_co2 = CO2_HIGH_RESET;
               lo_air = AIR_LOW_RESET;
               hi_air = AIR_HIGH_RESET;
               interval = INTERVAL_RESET;
            end
            1: begin
               lo_co2 = 0;
               hi_co2 = 0;
               lo_air = 0;
               hi_air = 0;
               interval = 0;
            end
            2: begin
               lo_co2 = CO2_MAX;
               hi_co2 = CO2_MAX;
               lo_air = AIR_MAX;
               hi_air = AIR_MAX;
               interval = INTERVAL_MAX;
            end
            3: interval = INTERVAL_FAST - 1;
            4: interval = INTERVAL_FAST;
            5: interval = $urandom_range(0, 29);
            default: begin
               lo_co2 = $urandom_range(0, CO2_MAX);
               hi_co2 = $urandom_range(0, CO2_MAX);
               lo_air = $urandom_range(0, AIR_MAX);
               hi_air = $urandom_range(0, AIR_MAX);
               interval = $urandom_range(0, INTERVAL_MAX);
            end
         endcase
         write_reg(CSR_CO2_LOW, lo_co2);
         write_reg(CSR_CO2_HIGH, hi_co2);
         write_reg(CSR_AIR_LOW, lo_air);
         write_reg(CSR_AIR_HIGH, hi_air);
         write_reg(CSR_INTERVAL, interval);
         csr_valid <= 1'b0;
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 66;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 66;
            end
            default: begin
               send_idle_pct = 31;
               stall_pct = 31;
            end
         endcase
         series_left = 0;
         repeat (ROWS_PER_PHASE) send_row(next_random_row(), 1'b0, '0);
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (6) @(posedge clock);
      if (mismatches == 0 && flags_due.size() == 0) begin
         $display("air_quality_sensor_plausibility verification clean");
      end else begin
         $display("air_quality_sensor_plausibility verification failed");
      end
      $finish;
   end

endmodule
